// ===== rtl/b64le_pkg.sv =====
// Shared types, constants and the symbol table of the line-wrapped base64 encoder.
package b64le_pkg;

  localparam logic [7:0] NewlineChar = 8'd10;
  localparam logic [7:0] PadChar     = 8'd61;
  localparam logic [3:0] LineGroupsMax = 4'd15;
  localparam logic [2:0] NewlinePos  = 3'd4;
  localparam logic [2:0] LastSymPos  = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       text_last;
  } out_req_t;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  pads;
    logic        newline;
    logic        last;
  } grp_t;

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd97 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'd48 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

// ===== rtl/b64le_front.sv =====
// Front part: collects bytes into groups and tracks line position.
module b64le_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64le_pkg::in_req_t  in_req_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output b64le_pkg::grp_t     q_data_o
);

  logic [15:0] held_q, held_d;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  line_q, line_d;
  logic        accept;
  logic        complete;
  b64le_pkg::grp_t grp;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    held_d   = held_q;
    phase_d  = phase_q;
    line_d   = line_q;
    complete = 1'b0;
    grp      = '0;
    case (phase_q)
      2'd0: begin
        if (in_req_i.final_byte) begin
          complete = 1'b1;
          grp.bits = {in_req_i.data_byte, 16'h0000};
          grp.pads = 2'd2;
        end else begin
          held_d  = {in_req_i.data_byte, 8'h00};
          phase_d = 2'd1;
        end
      end
      2'd1: begin
        if (in_req_i.final_byte) begin
          complete = 1'b1;
          grp.bits = {held_q[15:8], in_req_i.data_byte, 8'h00};
          grp.pads = 2'd1;
        end else begin
          held_d  = {held_q[15:8], in_req_i.data_byte};
          phase_d = 2'd2;
        end
      end
      default: begin
        complete = 1'b1;
        grp.bits = {held_q, in_req_i.data_byte};
        grp.pads = 2'd0;
      end
    endcase
    if (complete) begin
      held_d  = '0;
      phase_d = 2'd0;
      if (in_req_i.final_byte) begin
        grp.newline = 1'b1;
        grp.last    = 1'b1;
        line_d      = '0;
      end else if (line_q == b64le_pkg::LineGroupsMax) begin
        grp.newline = 1'b1;
        line_d      = '0;
      end else begin
        line_d = line_q + 4'd1;
      end
    end
  end

  assign q_push_o = accept && complete;
  assign q_data_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      phase_q <= '0;
      line_q  <= '0;
    end else if (accept) begin
      held_q  <= held_d;
      phase_q <= phase_d;
      line_q  <= line_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("group phase out of range");

  a_push_resets_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |=> phase_q == 2'd0 && held_q == 16'h0000)
    else $error("phase not cleared after group");

endmodule

// ===== rtl/b64le_fifo.sv =====
// Short queue of group requests between front and back.
module b64le_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64le_pkg::grp_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output b64le_pkg::grp_t  head_o,
  output logic             valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  b64le_pkg::grp_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntFull;
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrMax) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrMax) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count overflow");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into full queue");

endmodule

// ===== rtl/b64le_back.sv =====
// Back part: turns each group request into characters, one per cycle while the output is not stalled.
module b64le_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64le_pkg::grp_t     head_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  output b64le_pkg::out_req_t out_req_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);

  b64le_pkg::grp_t     cmd_q, cur;
  b64le_pkg::out_req_t out_q, chr;
  logic                out_valid_q, busy_q;
  logic [2:0]          pos_q, p, pad_sum;
  logic [5:0]          six;
  logic                go, at_end;

  assign cur     = busy_q ? cmd_q : head_i;
  assign p       = busy_q ? pos_q : 3'd0;
  assign pad_sum = p + {1'b0, cur.pads};
  assign at_end  = p == (cur.newline ? b64le_pkg::NewlinePos : b64le_pkg::LastSymPos);

  always_comb begin
    case (p[1:0])
      2'd0:    six = cur.bits[23:18];
      2'd1:    six = cur.bits[17:12];
      2'd2:    six = cur.bits[11:6];
      default: six = cur.bits[5:0];
    endcase
    chr.text_last = 1'b0;
    if (p == b64le_pkg::NewlinePos) begin
      chr.text_char = b64le_pkg::NewlineChar;
      chr.text_last = cur.last;
    end else if (pad_sum >= 3'd4) begin
      chr.text_char = b64le_pkg::PadChar;
    end else begin
      chr.text_char = b64le_pkg::b64_sym(six);
    end
  end

  assign go    = (!out_valid_q || !out_stall_i) && (busy_q || head_valid_i);
  assign pop_o = go && !busy_q;

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q <= chr;
    end
    if (pop_o) begin
      cmd_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      pos_q       <= '0;
    end else if (go) begin
      out_valid_q <= 1'b1;
      busy_q      <= !at_end;
      pos_q       <= at_end ? 3'd0 : p + 3'd1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_req_o   = out_q;
  assign out_valid_o = out_valid_q;

  a_last_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.text_last |-> out_q.text_char == b64le_pkg::NewlineChar)
    else $error("last mark on a non-newline character");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q != 3'd0 && pos_q <= b64le_pkg::NewlinePos)
    else $error("character position out of range");

endmodule

// ===== rtl/base64_line_wrapped_encoder_unit.sv =====
// Top level of the base64 encoder with 64-column line wrapping.
// Bytes enter one per cycle unless the queue is full; every third byte (or a final byte)
// forms a group request that waits in a short queue, and the serialiser emits one
// character per cycle while the output is not stalled: four characters per group plus
// a newline after every 16 groups and after the final group, whose newline alone
// carries text_last. Sustained throughput is set by the single-character output
// register; input stalls only while the queue is full.
module base64_line_wrapped_encoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64le_pkg::in_req_t  in_req_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output b64le_pkg::out_req_t out_req_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);

  logic            q_push, q_full, q_pop, q_valid;
  b64le_pkg::grp_t q_wdata, q_head;

  b64le_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  b64le_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .valid_o     (q_valid)
  );

  b64le_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_valid_i (q_valid),
    .pop_o        (q_pop),
    .out_req_o    (out_req_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

// ===== verif/b64le_stream_checker.sv =====
// Stream checker for the line-wrapped base64 encoder: predicts the text and compares.
`timescale 1ns / 1ps

module b64le_stream_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64le_pkg::in_req_t  in_req_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  b64le_pkg::out_req_t out_req_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_o
);

  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  b64le_pkg::out_req_t expected_text[$];
  b64le_pkg::out_req_t want;
  logic [15:0]         pend_bytes;
  logic [1:0]          pend_count;
  logic [3:0]          groups_on_line;
  int unsigned         mismatches;

  function automatic logic [7:0] symbol_of(input logic [5:0] v);
    return Alphabet[8*(63 - int'(v)) +: 8];
  endfunction

  task automatic push_char(input logic [7:0] c, input logic last);
    b64le_pkg::out_req_t r;
    r.text_char = c;
    r.text_last = last;
    expected_text.push_back(r);
  endtask

  task automatic encode_byte(input b64le_pkg::in_req_t req);
    logic [23:0] n;
    case (pend_count)
      2'd0: begin
        if (!req.final_byte) begin
          pend_bytes = {req.data_byte, 8'h00};
          pend_count = 2'd1;
          return;
        end
        n = {req.data_byte, 16'h0000};
        push_char(symbol_of(n[23:18]), 1'b0);
        push_char(symbol_of(n[17:12]), 1'b0);
        push_char(b64le_pkg::PadChar, 1'b0);
        push_char(b64le_pkg::PadChar, 1'b0);
      end
      2'd1: begin
        if (!req.final_byte) begin
          pend_bytes[7:0] = req.data_byte;
          pend_count = 2'd2;
          return;
        end
        n = {pend_bytes[15:8], req.data_byte, 8'h00};
        push_char(symbol_of(n[23:18]), 1'b0);
        push_char(symbol_of(n[17:12]), 1'b0);
        push_char(symbol_of(n[11:6]), 1'b0);
        push_char(b64le_pkg::PadChar, 1'b0);
      end
      default: begin
        n = {pend_bytes, req.data_byte};
        push_char(symbol_of(n[23:18]), 1'b0);
        push_char(symbol_of(n[17:12]), 1'b0);
        push_char(symbol_of(n[11:6]), 1'b0);
        push_char(symbol_of(n[5:0]), 1'b0);
      end
    endcase
    pend_bytes = 16'h0000;
    pend_count = 2'd0;
    if (req.final_byte) begin
      push_char(b64le_pkg::NewlineChar, 1'b1);
      groups_on_line = 4'd0;
    end else if (groups_on_line == 4'd15) begin
      push_char(b64le_pkg::NewlineChar, 1'b0);
      groups_on_line = 4'd0;
    end else begin
      groups_on_line = groups_on_line + 4'd1;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pend_bytes     = 16'h0000;
      pend_count     = 2'd0;
      groups_on_line = 4'd0;
      mismatches     = 0;
      expected_text.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        encode_byte(in_req_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected char expected none, actual %02h last %0b",
                   $time, out_req_i.text_char, out_req_i.text_last);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (out_req_i.text_char !== want.text_char) begin
            $display("%0t: text_char expected %02h, actual %02h",
                     $time, want.text_char, out_req_i.text_char);
            mismatches++;
          end
          if (out_req_i.text_last !== want.text_last) begin
            $display("%0t: text_last expected %0b, actual %0b",
                     $time, want.text_last, out_req_i.text_last);
            mismatches++;
          end
        end
      end
    end
    fail_cnt_o <= mismatches;
    pending_o  <= expected_text.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: clock, reset, byte stimulus, output stalls and the verdict for the encoder.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned ByteTarget  = 460;
  localparam int unsigned SettleWait  = 40;

  logic                clk_i;
  logic                rst_ni;
  b64le_pkg::in_req_t  in_req;
  logic                in_valid;
  logic                in_stall;
  b64le_pkg::out_req_t out_req;
  logic                out_valid;
  logic                out_stall;
  int unsigned         fail_cnt;
  int unsigned         pending;
  int unsigned         sent_cnt;
  int unsigned         cycle_cnt;

  base64_line_wrapped_encoder_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .out_req_o  (out_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall)
  );

  b64le_stream_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .out_req_i  (out_req),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    bit calm;
    calm = (sent_cnt >= 250 && sent_cnt < 330);
    while (!calm && $urandom_range(0, 99) < 18) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_req.data_byte  <= b;
    in_req.final_byte <= fin;
    in_valid          <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic send_message(input int unsigned len);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // hold off the output for a long stretch once, keep it free in a calm window, otherwise stall at random
  initial begin
    int unsigned hold_left;
    bit          pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    out_stall     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!pressure_done && sent_cnt >= 100) begin
        hold_left     = 120;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (sent_cnt >= 250 && sent_cnt < 330) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 18);
      end
    end
  end

  initial begin
    int unsigned len;
    in_req    = '0;
    in_valid  = 1'b0;
    sent_cnt  = 0;
    rst_ni    = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // one byte, two bytes, a full group, then partial groups after full ones
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h08, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b1);

    // full line on the final group
    send_message(48);
    while (sent_cnt < ByteTarget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(1, 6);
        4, 5, 6:    len = $urandom_range(7, 60);
        7, 8:       len = $urandom_range(45, 51);
        default:    len = $urandom_range(61, 130);
      endcase
      if (len > ByteTarget - sent_cnt) begin
        len = ByteTarget - sent_cnt;
      end
      send_message(len);
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== base64_line_wrapped_encoder_unit.f =====
rtl/b64le_pkg.sv
rtl/b64le_front.sv
rtl/b64le_fifo.sv
rtl/b64le_back.sv
rtl/base64_line_wrapped_encoder_unit.sv
verif/b64le_stream_checker.sv
verif/tb_top.sv
